### hdl/implicit_capture_roulette_defines.svh
// assertion macros for the implicit capture roulette block
// used by the port checker; needs clk and rst in scope
`ifndef IMPLICIT_CAPTURE_ROULETTE_DEFINES_SVH
`define IMPLICIT_CAPTURE_ROULETTE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ICR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ICR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/icr_pkg.sv
// shared types and constants for the implicit capture roulette block
// no dependencies; imported by every module of the block
package icr_pkg;

  localparam int WEIGHT_W      = 32;
  localparam int XS_W          = 32;
  localparam int RANDOM_W      = 24;
  localparam int CUTOFF_W      = 31;
  localparam int FRACTION_BITS = 24;
  localparam int PROD_W        = WEIGHT_W + FRACTION_BITS;
  localparam int TEST_W        = RANDOM_W + WEIGHT_W;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CUTOFF   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INCLUDE_FISSION = CFG_INDEX_W'(1);

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(4194304);

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_in;
    logic [XS_W-1:0]     absorption_xs;
    logic [XS_W-1:0]     fission_xs;
    logic [XS_W-1:0]     total_xs;
    logic [RANDOM_W-1:0] random_fraction;
  } collision_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_out;
    logic [WEIGHT_W-1:0] absorbed_weight;
    logic                killed;
    logic                rouletted;
    logic                bad_cross_section;
  } result_t;

  // item state while the removal fraction is worked out bit by bit
  typedef struct packed {
    logic [WEIGHT_W-1:0]      weight_in;
    logic [RANDOM_W-1:0]      random_fraction;
    logic [XS_W-1:0]          total_xs;
    logic [XS_W-1:0]          remainder;
    logic [FRACTION_BITS-1:0] quotient;
    logic                     full;
    logic                     bad;
  } div_t;

endpackage

### hdl/implicit_capture_roulette.sv
// top level of the implicit capture roulette block: registers and pipeline
// depends on icr_pkg, icr_front, icr_div_step, icr_back
//
//   channel     signals                              payload
//   collision   collision_valid / collision_ready    collision_t
//   result      result_valid / result_ready          result_t
//   cfg         cfg_valid / cfg_ready                cfg_index, cfg_data
//
// one input stage, one divider stage per fraction bit, then multiply,
// subtract and result stages; one beat per cycle enters and leaves while
// result_ready stays high.
// reset is synchronous, clears every valid bit and resets the config registers.
// each stage advances when it or the stage after it is free, so bubbles
// close up under a stalled result and no beat is lost or repeated.
module implicit_capture_roulette (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            collision_valid,
  output logic                            collision_ready,
  input  icr_pkg::collision_t             collision,
  output logic                            result_valid,
  input  logic                            result_ready,
  output icr_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [icr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import icr_pkg::*;

  logic [CUTOFF_W-1:0] weight_cutoff;
  logic                include_fission;

  logic [FRACTION_BITS:0] stg_valid;
  logic [FRACTION_BITS:0] stg_ready;
  div_t                   stg_data [FRACTION_BITS+1];

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_cutoff   <= CUTOFF_RESET;
      include_fission <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WEIGHT_CUTOFF:   weight_cutoff   <= cfg_data[CUTOFF_W-1:0];
        REG_INCLUDE_FISSION: include_fission <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // removal sum and clamp
  icr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .include_fission (include_fission),
    .up_valid        (collision_valid),
    .up_ready        (collision_ready),
    .up              (collision),
    .dn_valid        (stg_valid[0]),
    .dn_ready        (stg_ready[0]),
    .dn              (stg_data[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
    icr_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up       (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn       (stg_data[k+1])
    );
  end

  // capture, roulette and result register
  icr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .weight_cutoff (weight_cutoff),
    .up_valid      (stg_valid[FRACTION_BITS]),
    .up_ready      (stg_ready[FRACTION_BITS]),
    .up            (stg_data[FRACTION_BITS]),
    .dn_valid      (result_valid),
    .dn_ready      (result_ready),
    .dn            (result)
  );

endmodule

### hdl/icr_front.sv
// input stage: removal sum, clamp and zero-total detection
// depends on icr_pkg
module icr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              include_fission,
  input  logic              up_valid,
  output logic              up_ready,
  input  icr_pkg::collision_t up,
  output logic              dn_valid,
  input  logic              dn_ready,
  output icr_pkg::div_t     dn
);
  import icr_pkg::*;

  logic          en;
  logic [XS_W:0] removal;
  logic          full;
  div_t          dn_next;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  // removal sum in one extra bit, clamp when it reaches total
  always_comb begin
    removal = {1'b0, up.absorption_xs} +
              (include_fission ? {1'b0, up.fission_xs} : {1'b0, XS_W'(0)});
    full    = removal >= {1'b0, up.total_xs};
    dn_next.weight_in       = up.weight_in;
    dn_next.random_fraction = up.random_fraction;
    dn_next.total_xs        = up.total_xs;
    dn_next.remainder       = full ? XS_W'(0) : removal[XS_W-1:0];
    dn_next.quotient        = '0;
    dn_next.full            = full;
    dn_next.bad             = up.total_xs == XS_W'(0);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
    if (en && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

### hdl/icr_div_step.sv
// one restoring-division stage: one quotient bit of removal / total
// depends on icr_pkg
module icr_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  icr_pkg::div_t up,
  output logic          dn_valid,
  input  logic          dn_ready,
  output icr_pkg::div_t dn
);
  import icr_pkg::*;

  logic          en;
  logic [XS_W:0] shifted;
  logic [XS_W:0] diff;
  logic          ge;
  div_t          dn_next;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  // remainder stays below total, so the doubled value fits one extra bit
  always_comb begin
    shifted = {up.remainder, 1'b0};
    ge      = shifted >= {1'b0, up.total_xs};
    diff    = shifted - {1'b0, up.total_xs};
    dn_next           = up;
    dn_next.remainder = ge ? diff[XS_W-1:0] : shifted[XS_W-1:0];
    dn_next.quotient  = {up.quotient[FRACTION_BITS-2:0], ge};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
    if (en && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

### hdl/icr_back.sv
// capture multiply, remaining weight and roulette decision, three stages
// depends on icr_pkg; last stage is the result register
module icr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [icr_pkg::CUTOFF_W-1:0] weight_cutoff,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  icr_pkg::div_t         up,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output icr_pkg::result_t      dn
);
  import icr_pkg::*;

  // multiply stage
  logic                m_valid;
  logic [PROD_W-1:0]   m_prod;
  logic [WEIGHT_W-1:0] m_weight;
  logic [RANDOM_W-1:0] m_random;
  logic                m_full;
  logic                m_bad;
  // subtract stage
  logic                s_valid;
  logic [WEIGHT_W-1:0] s_weight;
  logic [WEIGHT_W-1:0] s_absorbed;
  logic [WEIGHT_W-1:0] s_remaining;
  logic [TEST_W-1:0]   s_test;
  logic                s_bad;

  logic                m_en;
  logic                s_en;
  logic                f_en;
  logic [WEIGHT_W-1:0] absorbed_next;
  logic [WEIGHT_W-1:0] cutoff2;
  logic                below;
  logic                survive;
  result_t             dn_next;

  assign f_en     = !dn_valid || dn_ready;
  assign s_en     = !s_valid || f_en;
  assign m_en     = !m_valid || s_en;
  assign up_ready = m_en;
  assign cutoff2  = {weight_cutoff, 1'b0};

  // weight times fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_en) begin
      m_valid <= up_valid;
    end
    if (m_en && up_valid) begin
      m_prod   <= PROD_W'(up.weight_in) * PROD_W'(up.quotient);
      m_weight <= up.weight_in;
      m_random <= up.random_fraction;
      m_full   <= up.full;
      m_bad    <= up.bad;
    end
  end

  // absorbed weight: whole weight when the fraction clamps to one
  assign absorbed_next = m_full ? m_weight : m_prod[FRACTION_BITS +: WEIGHT_W];

  // remaining weight and the roulette product
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_en) begin
      s_valid <= m_valid;
    end
    if (s_en && m_valid) begin
      s_weight    <= m_weight;
      s_absorbed  <= absorbed_next;
      s_remaining <= m_weight - absorbed_next;
      s_test      <= TEST_W'(m_random) * TEST_W'(cutoff2);
      s_bad       <= m_bad;
    end
  end

  // roulette decision and result fields
  always_comb begin
    below   = s_remaining < {1'b0, weight_cutoff};
    survive = s_test < {s_remaining, RANDOM_W'(0)};
    if (s_bad) begin
      dn_next.weight_out        = s_weight;
      dn_next.absorbed_weight   = '0;
      dn_next.killed            = 1'b0;
      dn_next.rouletted         = 1'b0;
      dn_next.bad_cross_section = 1'b1;
    end else begin
      dn_next.absorbed_weight   = s_absorbed;
      dn_next.rouletted         = below;
      dn_next.killed            = below && !survive;
      dn_next.bad_cross_section = 1'b0;
      if (!below) begin
        dn_next.weight_out = s_remaining;
      end else if (survive) begin
        dn_next.weight_out = cutoff2;
      end else begin
        dn_next.weight_out = '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (f_en) begin
      dn_valid <= s_valid;
    end
    if (f_en && s_valid) begin
      dn <= dn_next;
    end
  end

endmodule

### hdl/icr_checker.sv
// port-level checks for the implicit capture roulette block, with its bind
// depends on icr_pkg and implicit_capture_roulette_defines.svh
`include "implicit_capture_roulette_defines.svh"

module icr_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input icr_pkg::result_t result
);
  import icr_pkg::*;

  // a waiting result beat stays up
  `ICR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result beat dropped while stalled")

  // a waiting result beat keeps its payload
  `ICR_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result), "result payload changed while stalled")

  // a zero-total beat carries no capture and no roulette
  `ICR_ASSERT_NOW(a_bad_clean, result_valid && result.bad_cross_section, !result.killed && !result.rouletted && result.absorbed_weight == '0, "bad cross section beat carries capture or roulette")

  // a kill only comes from roulette and reports zero weight
  `ICR_ASSERT_NOW(a_kill_zero, result_valid && result.killed, result.rouletted && result.weight_out == '0, "killed beat with weight or without roulette")

endmodule

bind implicit_capture_roulette icr_checker u_icr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### tb/sv/implicit_capture_roulette_checker.sv
// result checker for the implicit capture roulette block
// depends on icr_pkg; watches the collision, result and cfg channels
// and predicts each result beat from its collision beat and the settings
module implicit_capture_roulette_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            collision_valid,
  input  logic                            collision_ready,
  input  icr_pkg::collision_t             collision,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  icr_pkg::result_t                result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [icr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [icr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              outcomes_in_flight
);
  import icr_pkg::*;

  logic [CUTOFF_W-1:0] cutoff_setting;
  logic                fission_setting;
  result_t             predicted_outcomes[$];
  result_t             oldest;
  int                  results_seen;

  // implicit capture followed by russian roulette below the cutoff
  function automatic result_t predict_capture(collision_t c, logic [CUTOFF_W-1:0] cutoff,
                                              logic fission_on);
    result_t       r;
    logic [XS_W:0] removal;
    logic [63:0]   fraction;
    logic [63:0]   absorbed;
    logic [63:0]   remaining;
    logic [63:0]   survive_weight;
    r = '0;
    // zero total cross section passes the weight through
    if (c.total_xs == '0) begin
      r.weight_out        = c.weight_in;
      r.bad_cross_section = 1'b1;
      return r;
    end
    removal = {1'b0, c.absorption_xs};
    if (fission_on) begin
      removal = removal + {1'b0, c.fission_xs};
    end
    // removed fraction, clamped to one
    if (removal >= {1'b0, c.total_xs}) begin
      fraction = 64'(1) << FRACTION_BITS;
    end else begin
      fraction = (64'(removal) << FRACTION_BITS) / 64'(c.total_xs);
    end
    absorbed  = (64'(c.weight_in) * fraction) >> FRACTION_BITS;
    remaining = 64'(c.weight_in) - absorbed;
    // roulette: survive at twice the cutoff or die
    if (remaining < 64'(cutoff)) begin
      r.rouletted    = 1'b1;
      survive_weight = 64'(cutoff) << 1;
      if (64'(c.random_fraction) * survive_weight < (remaining << RANDOM_W)) begin
        remaining = survive_weight;
      end else begin
        remaining = '0;
        r.killed  = 1'b1;
      end
    end
    r.weight_out      = remaining[WEIGHT_W-1:0];
    r.absorbed_weight = absorbed[WEIGHT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: result beat %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      cutoff_setting  = CUTOFF_RESET;
      fission_setting = 1'b0;
      mismatch_count  = 0;
      results_seen    = 0;
      predicted_outcomes.delete();
    end else begin
      // result beat against the oldest prediction
      if (result_valid && result_ready) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch("result beat with no collision waiting");
        end else begin
          oldest = predicted_outcomes.pop_front();
          compare_field("weight_out", 64'(oldest.weight_out), 64'(result.weight_out));
          compare_field("absorbed_weight", 64'(oldest.absorbed_weight),
                        64'(result.absorbed_weight));
          compare_field("killed", 64'(oldest.killed), 64'(result.killed));
          compare_field("rouletted", 64'(oldest.rouletted), 64'(result.rouletted));
          compare_field("bad_cross_section", 64'(oldest.bad_cross_section),
                        64'(result.bad_cross_section));
        end
        results_seen++;
      end
      // collision beat
      if (collision_valid && collision_ready) begin
        predicted_outcomes.push_back(predict_capture(collision, cutoff_setting,
                                                     fission_setting));
      end
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WEIGHT_CUTOFF:   cutoff_setting = cfg_data[CUTOFF_W-1:0];
          REG_INCLUDE_FISSION: fission_setting = cfg_data[0];
          default: ;
        endcase
      end
    end
    outcomes_in_flight = predicted_outcomes.size();
  end

endmodule

### tb/sv/implicit_capture_roulette_test.sv
// top of the implicit capture roulette testbench: clock, reset and stimulus
// depends on icr_pkg, implicit_capture_roulette and implicit_capture_roulette_checker
module implicit_capture_roulette_test;
  import icr_pkg::*;

  localparam int LONG_HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   collision_valid;
  logic                   collision_ready;
  collision_t             collision;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatch_count;
  int                     outcomes_in_flight;

  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;

  implicit_capture_roulette dut (
    .clk             (clk),
    .rst             (rst),
    .collision_valid (collision_valid),
    .collision_ready (collision_ready),
    .collision       (collision),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  implicit_capture_roulette_checker capture_check (
    .clk                (clk),
    .rst                (rst),
    .collision_valid    (collision_valid),
    .collision_ready    (collision_ready),
    .collision          (collision),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result             (result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .outcomes_in_flight (outcomes_in_flight)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts, and one long hold on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        result_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // random collision, biased toward heavy capture and small weights
  function automatic collision_t random_collision();
    collision_t c;
    c.weight_in       = $urandom >> $urandom_range(0, 12);
    c.absorption_xs   = $urandom;
    c.fission_xs      = $urandom >> $urandom_range(0, 31);
    c.total_xs        = $urandom;
    c.random_fraction = RANDOM_W'($urandom);
    case ($urandom_range(0, 9))
      // zero total cross section
      0: c.total_xs = '0;
      // full-range weight
      1, 2: c.weight_in = $urandom;
      // nearly total capture, pushes the weight under the cutoff
      3: c.absorption_xs = c.total_xs - (c.total_xs >> $urandom_range(1, 31));
      default: begin
        c.total_xs      = ($urandom >> $urandom_range(0, 28)) | XS_W'(1);
        c.absorption_xs = $urandom_range(0, c.total_xs);
      end
    endcase
    return c;
  endfunction

  // one collision beat, with an optional idle burst ahead of it
  task automatic send_collision(collision_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      collision_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    collision_valid <= 1'b1;
    collision       <= c;
    @(posedge clk);
    while (!collision_ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    collision_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outcomes_in_flight != 0);
  endtask

  // register beat; valid is left high for a following write
  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // settings change once the pipeline is empty; spare data bits are random
  task automatic apply_settings(logic [CUTOFF_W-1:0] cutoff, logic fission_on);
    stop_sending();
    wait_drained();
    write_register(REG_WEIGHT_CUTOFF, {1'($urandom), cutoff});
    write_register(CFG_INDEX_W'($urandom_range(2, 255)), $urandom);
    write_register(REG_INCLUDE_FISSION, {31'($urandom), fission_on});
    cfg_valid <= 1'b0;
  endtask

  // random collisions, with an optional long result hold and sender pause
  task automatic run_random(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_request = 1'b1;
      end
      if (i == pause_at) begin
        stop_sending();
        wait_drained();
      end
      send_collision(random_collision());
    end
  endtask

  // stimulus and verdict
  initial begin
    rst             = 1'b1;
    collision_valid = 1'b0;
    collision       = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: quarter cutoff, absorption only
    send_collision(collision_t'{32'h0, 32'h0, 32'h0, 32'h0, 24'h0});
    send_collision(collision_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 24'hFF_FFFF});
    send_collision(collision_t'{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0});
    send_collision(collision_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                24'hFF_FFFF});
    send_collision(collision_t'{32'h0100_0000, 32'h5, 32'h0, 32'h3, 24'h0});
    send_collision(collision_t'{32'h0040_0000, 32'h0, 32'h0, 32'h1, 24'h0});
    send_collision(collision_t'{32'h003F_FFFF, 32'h0, 32'h0, 32'h1, 24'h0});
    send_collision(collision_t'{32'h003F_FFFF, 32'h0, 32'h0, 32'h1, 24'hFF_FFFF});
    send_collision(collision_t'{32'h0100_0000, 32'h1, 32'h0, 32'h2, 24'h80_0000});
    send_collision(collision_t'{32'h0000_0001, 32'h1, 32'h0, 32'h3, 24'h0});
    send_collision(collision_t'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                24'h12_3456});
    run_random(60, -1, -1);

    // largest cutoff, fission counted; long result hold midway
    apply_settings(31'h7FFF_FFFF, 1'b1);
    send_collision(collision_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                24'h0});
    send_collision(collision_t'{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 24'h0});
    send_collision(collision_t'{32'h7FFF_FFFE, 32'h0, 32'h0, 32'h1, 24'hFF_FFFF});
    send_collision(collision_t'{32'h7FFF_FFFE, 32'h0, 32'h0, 32'h1, 24'h0});
    send_collision(collision_t'{32'h1000_0000, 32'h1, 32'h1, 32'h4, 24'h0});
    send_collision(collision_t'{32'h1000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                24'h0});
    run_random(70, 20, -1);

    // zero cutoff: roulette never plays
    apply_settings(31'h0, 1'b0);
    send_collision(collision_t'{32'h0, 32'h0, 32'h0, 32'h1, 24'h0});
    send_collision(collision_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 24'hFF_FFFF});
    run_random(70, -1, -1);

    // zero cutoff with fission; sender waits for an empty pipeline midway
    apply_settings(31'h0, 1'b1);
    run_random(60, -1, 30);

    apply_settings(31'($urandom_range(1, 32'h0400_0000)), 1'($urandom));
    run_random(80, -1, -1);

    // smallest nonzero cutoff, no idling
    idle_on = 1'b0;
    apply_settings(31'h1, 1'b0);
    run_random(60, -1, -1);

    idle_on = 1'b1;
    apply_settings(31'h0040_0000, 1'b1);
    run_random(70, -1, -1);

    // closing stretch without idling
    idle_on = 1'b0;
    apply_settings(31'h0080_0000, 1'b0);
    run_random(80, -1, -1);

    stop_sending();
    wait_drained();
    repeat (FRACTION_BITS + 8) @(posedge clk);
    if (mismatch_count == 0 && outcomes_in_flight == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
